// File: rtl/mec_pkg.sv
package mec_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int INDEX_WIDTH = 12;
  localparam int COUNT_WIDTH = 16;

  // Configuration register widths as seen on the port.
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int LIMIT_W = 16;
  localparam int CFG_IDX_W = 3;

  // Working values carry three integer bits and a sign (about +-8).
  localparam int WORK_W = FRAC_BITS + 4;
  localparam int MUL_W  = (WORK_W > STEP_W) ? WORK_W : STEP_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = ((WORK_W > COORD_W) ? WORK_W : COORD_W) + 2;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(4);

  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t MAXV = {1'b0, {(WORK_W-1){1'b1}}};
  localparam work_t MINV = {1'b1, {(WORK_W-1){1'b0}}};

  localparam logic [PROD_W-1:0] MAXV_P = PROD_W'(MAXV);
  localparam logic [PROD_W-1:0] LIM_P  = PROD_W'(1) << (WORK_W - 1);
  localparam logic [WORK_W:0]   FOUR   = (WORK_W + 1)'(4) << FRAC_BITS;

  // One request to the shared multiplier: two magnitudes and the sign of the product.
  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    logic             neg;
  } mul_req_t;

  // Saturate a wide signed sum into the working range.
  function automatic work_t sat_sum(input logic signed [SUM_W-1:0] s);
    work_t r;
    if (s > SUM_W'(MAXV)) begin
      r = MAXV;
    end else if (s < SUM_W'(MINV)) begin
      r = MINV;
    end else begin
      r = s[WORK_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a working value; the most negative value maps to 2^(WORK_W-1).
  function automatic logic [MUL_W-1:0] mag(input work_t x);
    logic [WORK_W-1:0] t;
    t = x[WORK_W-1] ? WORK_W'(-x) : WORK_W'(x);
    return MUL_W'(t);
  endfunction

  // Drop the fraction bits of a product magnitude (truncation toward zero),
  // apply the sign and saturate.
  function automatic work_t fix_scale(input logic [PROD_W-1:0] p, input logic neg);
    logic [PROD_W-1:0] q;
    work_t             r;
    q = p >> FRAC_BITS;
    if (neg) begin
      if (q >= LIM_P) begin
        r = MINV;
      end else begin
        r = -work_t'(q[WORK_W-1:0]);
      end
    end else begin
      if (q > MAXV_P) begin
        r = MAXV;
      end else begin
        r = work_t'(q[WORK_W-1:0]);
      end
    end
    return r;
  endfunction

  // Saturate an unsigned pixel offset into the positive working range.
  function automatic work_t off_sat(input logic [PROD_W-1:0] p);
    work_t r;
    if (p > MAXV_P) begin
      r = MAXV;
    end else begin
      r = work_t'(p[WORK_W-1:0]);
    end
    return r;
  endfunction

endpackage

// File: rtl/mec_mul_unit.sv
module mec_mul_unit (
  input  logic                         clk_i,
  input  mec_pkg::mul_req_t            req_i,
  output logic [mec_pkg::PROD_W-1:0]   prod_o,
  output logic                         neg_o
);

  logic [mec_pkg::PROD_W-1:0] prod_q;
  logic                       neg_q;

  // Unsigned magnitude product, registered before any use.
  always_ff @(posedge clk_i) begin
    prod_q <= mec_pkg::PROD_W'(req_i.a) * mec_pkg::PROD_W'(req_i.b);
    neg_q  <= req_i.neg;
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

// File: rtl/mandelbrot_escape_counter_core.sv
// Escape-time counter for one pixel, built around a single shared multiplier.
// Sequence: the cx and cy products, then per iteration the escape test, the update of
// u and v, and the squares of u and v. The number of iterations done is the final
// count - 1 (inside the set, limit - 1, or none for a limit below two). The next pixel
// is taken once the sequencer is back in idle, so one pixel is worked at a time, and an
// earlier result that is still stalled holds the last step of the next pixel.
// Reset (asynchronous, active low) idles the sequencer, drops the output valid
// and loads the default view: x_min -2.0, y_max 1.0, steps 2^-10, limit 1000.
module mandelbrot_escape_counter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mec_pkg::COORD_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mec_pkg::INDEX_WIDTH-1:0]     column_i,
  input  logic [mec_pkg::INDEX_WIDTH-1:0]     row_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mec_pkg::COUNT_WIDTH-1:0]     escape_count_o,
  output logic                                inside_set_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULY = 3'd1;
  localparam logic [2:0] S_CY   = 3'd2;
  localparam logic [2:0] S_TEST = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_MUU  = 3'd5;
  localparam logic [2:0] S_MVV  = 3'd6;
  localparam logic [2:0] S_SQV  = 3'd7;

  logic signed [mec_pkg::COORD_W-1:0] x_min_q, y_max_q;
  logic [mec_pkg::STEP_W-1:0]         step_x_q, step_y_q;
  logic [mec_pkg::LIMIT_W-1:0]        max_iter_q;

  logic [2:0]                         state_q, state_d;
  logic [mec_pkg::INDEX_WIDTH-1:0]    row_q;
  mec_pkg::work_t                     cx_q, cy_q, u_q, v_q, u2_q, v2_q;
  mec_pkg::work_t                     cx_d, cy_d, u_d, v_d, m_d, m2_d, sq_d;
  logic [mec_pkg::COUNT_WIDTH-1:0]    k_q, limit;
  logic [mec_pkg::WORK_W:0]           mag_sum;

  logic                               out_valid_q;
  logic [mec_pkg::COUNT_WIDTH-1:0]    count_q;
  logic                               inside_q;

  logic                               accept, cont, finish;

  mec_pkg::mul_req_t                  mul_req;
  logic [mec_pkg::PROD_W-1:0]         prod;
  logic                               prod_neg;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= 32'shE0000000;
      y_max_q    <= 32'sh10000000;
      step_x_q   <= 31'd262144;
      step_y_q   <= 31'd262144;
      max_iter_q <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mec_pkg::REG_X_MIN:    x_min_q    <= cfg_wdata_i;
        mec_pkg::REG_Y_MAX:    y_max_q    <= cfg_wdata_i;
        mec_pkg::REG_STEP_X:   step_x_q   <= cfg_wdata_i[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_STEP_Y:   step_y_q   <= cfg_wdata_i[mec_pkg::STEP_W-1:0];
        mec_pkg::REG_MAX_ITER: max_iter_q <= cfg_wdata_i[mec_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit   = max_iter_q[mec_pkg::COUNT_WIDTH-1:0];
  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign mag_sum = {1'b0, u2_q} + {1'b0, v2_q};
  assign cont    = (k_q < limit) && (mag_sum < mec_pkg::FOUR);
  assign finish  = (state_q == S_TEST) && !cont && (!out_valid_q || !out_stall_i);

  // Operand selection for the shared multiplier. In the idle state it
  // speculatively forms column * step_x from the port.
  always_comb begin
    mul_req.a   = mec_pkg::MUL_W'(column_i);
    mul_req.b   = mec_pkg::MUL_W'(step_x_q);
    mul_req.neg = 1'b0;
    unique case (state_q)
      S_MULY: begin
        mul_req.a = mec_pkg::MUL_W'(row_q);
        mul_req.b = mec_pkg::MUL_W'(step_y_q);
      end
      S_TEST: begin
        mul_req.a   = mec_pkg::mag(u_q);
        mul_req.b   = mec_pkg::mag(v_q);
        mul_req.neg = u_q[mec_pkg::WORK_W-1] ^ v_q[mec_pkg::WORK_W-1];
      end
      S_MUU: begin
        mul_req.a = mec_pkg::mag(u_q);
        mul_req.b = mec_pkg::mag(u_q);
      end
      S_MVV: begin
        mul_req.a = mec_pkg::mag(v_q);
        mul_req.b = mec_pkg::mag(v_q);
      end
      default: ;
    endcase
  end

  mec_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod),
    .neg_o  (prod_neg)
  );

  // Datapath arithmetic on the registered product.
  always_comb begin
    cx_d = mec_pkg::sat_sum(
             mec_pkg::SUM_W'(mec_pkg::sat_sum(mec_pkg::SUM_W'(x_min_q)))
             + mec_pkg::SUM_W'(mec_pkg::off_sat(prod)));
    cy_d = mec_pkg::sat_sum(
             mec_pkg::SUM_W'(mec_pkg::sat_sum(mec_pkg::SUM_W'(y_max_q)))
             - mec_pkg::SUM_W'(mec_pkg::off_sat(prod)));
    sq_d = mec_pkg::fix_scale(prod, prod_neg);
    m_d  = sq_d;
    m2_d = mec_pkg::sat_sum(mec_pkg::SUM_W'(m_d) + mec_pkg::SUM_W'(m_d));
    v_d  = mec_pkg::sat_sum(mec_pkg::SUM_W'(m2_d) + mec_pkg::SUM_W'(cy_q));
    // The difference of two non-negative squares cannot leave the range.
    u_d  = mec_pkg::sat_sum(mec_pkg::SUM_W'(u2_q) - mec_pkg::SUM_W'(v2_q)
                            + mec_pkg::SUM_W'(cx_q));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_MULY;
      S_MULY: state_d = S_CY;
      S_CY:   state_d = S_TEST;
      S_TEST: begin
        if (cont) begin
          state_d = S_UPD;
        end else if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_UPD:  state_d = S_MUU;
      S_MUU:  state_d = S_MVV;
      S_MVV:  state_d = S_SQV;
      S_SQV:  state_d = S_TEST;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= row_i;
      u_q   <= '0;
      v_q   <= '0;
      u2_q  <= '0;
      v2_q  <= '0;
      k_q   <= mec_pkg::COUNT_WIDTH'(1);
    end
    unique case (state_q)
      S_MULY: cx_q <= cx_d;
      S_CY:   cy_q <= cy_d;
      S_UPD: begin
        u_q <= u_d;
        v_q <= v_d;
      end
      S_MVV:  u2_q <= sq_d;
      S_SQV: begin
        v2_q <= sq_d;
        k_q  <= k_q + mec_pkg::COUNT_WIDTH'(1);
      end
      default: ;
    endcase
    if (finish) begin
      if (k_q >= limit) begin
        count_q  <= '0;
        inside_q <= 1'b1;
      end else begin
        count_q  <= k_q;
        inside_q <= 1'b0;
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = count_q;
  assign inside_set_o   = inside_q;

  // A new result only appears when the escape test has just ended a pixel.
  a_result_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_TEST)
    else $error("result appeared outside the escape test");

  // Points inside the set always report a zero count.
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inside_q) |-> (count_q == '0))
    else $error("inside-set result carries a nonzero count");

  // The iteration counter starts at one and never wraps during a pixel.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_MULY) |-> (k_q != '0))
    else $error("iteration counter wrapped");

  // Squared magnitudes feeding the escape test are never negative.
  a_squares_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> (!u2_q[mec_pkg::WORK_W-1] && !v2_q[mec_pkg::WORK_W-1]))
    else $error("negative square reached the escape test");

endmodule
